FILE: design/mwm_pkg.sv
`timescale 1ns / 1ps
// Package for the maze wall map: grid sizes, state encoding and cell helpers.
package mwm_pkg;

	localparam int GRID_WIDTH  = 16;
	localparam int GRID_HEIGHT = 16;
	localparam int CELL_CNT    = GRID_WIDTH * GRID_HEIGHT;
	localparam int CELL_AW     = $clog2(CELL_CNT);

	localparam logic [1:0] DIR_WEST  = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_NORTH = 2'd3;

	localparam logic [3:0] BOTH_VIEWS = 4'hF;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef logic [CELL_AW-1:0] cell_addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_NB_RD,
		ST_NB_WR,
		ST_CELL_RD,
		ST_CELL_WAIT,
		ST_DONE
	} state_t;

	function automatic logic in_grid(input logic [3:0] x, input logic [3:0] y);
		return (32'(x) < GRID_WIDTH) && (32'(y) < GRID_HEIGHT);
	endfunction

	function automatic cell_addr_t cell_addr(input logic [3:0] x, input logic [3:0] y);
		return CELL_AW'(32'(y) * GRID_WIDTH + 32'(x));
	endfunction

	function automatic logic [3:0] border_bits(input logic [3:0] x, input logic [3:0] y);
		logic [3:0] b;
		b = 4'd0;
		if (x == 4'd0)
			b[DIR_WEST] = 1'b1;
		else if (32'(x) == GRID_WIDTH - 1)
			b[DIR_EAST] = 1'b1;
		if (y == 4'd0)
			b[DIR_SOUTH] = 1'b1;
		else if (32'(y) == GRID_HEIGHT - 1)
			b[DIR_NORTH] = 1'b1;
		return b;
	endfunction

	function automatic logic [7:0] reset_cell(input logic [3:0] x, input logic [3:0] y);
		return {BOTH_VIEWS, border_bits(x, y)};
	endfunction

	function automatic logic [3:0] sensed_walls(input logic [1:0] hd, input logic left,
			input logic front, input logic right);
		logic [3:0] w;
		w = 4'd0;
		if (front)
			w[hd] = 1'b1;
		if (left)
			w[hd + 2'd1] = 1'b1;
		if (right)
			w[hd + 2'd3] = 1'b1;
		return w;
	endfunction

endpackage

FILE: design/maze_wall_map_update.sv
`timescale 1ns / 1ps
// Maze wall map store: record sensed walls into a cell and its neighbors, or read a cell.
//
//  channel | signals                                   | dir | role
//  in      | in_valid in_ready kind pos_x pos_y         | in  | record or read transaction
//          | heading left_seen front_seen right_seen    |     |
//  out     | out_valid out_ready cell_value             | out | one cell value per transaction
//
// A read passes through ST_CELL_RD and ST_CELL_WAIT, a record through ST_CENTER and then
// the four neighbors in turn, and an off-grid position goes straight to ST_DONE. A neighbor
// inside the grid costs a read and a write on the cell memory, one outside a single skip.
// in_ready is high only while the sequencer is idle.
// Reset needs no clearing pass: per-cell valid flops make unwritten cells read as their
// reset pattern. The result waits in the output register while out_ready is low.
module maze_wall_map_update
	import mwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [3:0] pos_x,
	input  logic [3:0] pos_y,
	input  logic [1:0] heading,
	input  logic       left_seen,
	input  logic       front_seen,
	input  logic       right_seen,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_value
);

	state_t state_q, state_d;

	logic [3:0] x_q, y_q;
	logic [3:0] walls_q;
	logic [1:0] dir_q;
	logic [7:0] res_q;
	logic       out_valid_q;
	logic [7:0] cell_value_q;

	logic [7:0] mem [CELL_CNT];
	logic       vld_q [CELL_CNT];
	logic [7:0] rd_data_q;
	logic       rd_vld_q;

	logic       mem_we;
	cell_addr_t mem_wa;
	logic [7:0] mem_wd;
	cell_addr_t mem_ra;

	logic       in_acc;
	logic       out_load;
	logic [3:0] nb_x, nb_y;
	logic       nb_exists;
	logic [1:0] nb_face;
	logic [7:0] nb_mask;
	logic [7:0] nb_cell;
	logic [7:0] rd_cell;
	logic [3:0] walls_in;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign walls_in  = sensed_walls(heading, left_seen, front_seen, right_seen)
		| border_bits(pos_x, pos_y);

	// neighbor in direction dir_q
	always_comb begin
		nb_x      = x_q;
		nb_y      = y_q;
		nb_exists = 1'b0;
		unique case (dir_q)
			DIR_NORTH: begin
				nb_y      = y_q + 4'd1;
				nb_exists = (32'(y_q) != GRID_HEIGHT - 1);
			end
			DIR_EAST: begin
				nb_x      = x_q + 4'd1;
				nb_exists = (32'(x_q) != GRID_WIDTH - 1);
			end
			DIR_SOUTH: begin
				nb_y      = y_q - 4'd1;
				nb_exists = (y_q != 4'd0);
			end
			default: begin
				nb_x      = x_q - 4'd1;
				nb_exists = (x_q != 4'd0);
			end
		endcase
	end

	assign nb_face = dir_q ^ 2'd2;
	assign nb_mask = 8'((9'd1 << nb_face) | (9'd1 << (3'(nb_face) + 3'd4)));
	assign rd_cell = rd_vld_q ? rd_data_q
		: reset_cell((state_q == ST_NB_WR) ? nb_x : x_q, (state_q == ST_NB_WR) ? nb_y : y_q);
	assign nb_cell = walls_q[dir_q] ? (rd_cell | nb_mask) : (rd_cell & ~nb_mask);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!in_grid(pos_x, pos_y))
						state_d = ST_DONE;
					else if (kind == KIND_READ)
						state_d = ST_CELL_RD;
					else
						state_d = ST_CENTER;
				end
			end
			ST_CENTER:    state_d = ST_NB_RD;
			ST_NB_RD: begin
				if (nb_exists)
					state_d = ST_NB_WR;
				else if (dir_q == DIR_WEST)
					state_d = ST_DONE;
			end
			ST_NB_WR:     state_d = (dir_q == DIR_WEST) ? ST_DONE : ST_NB_RD;
			ST_CELL_RD:   state_d = ST_CELL_WAIT;
			ST_CELL_WAIT: state_d = ST_DONE;
			ST_DONE:      state_d = out_load ? ST_IDLE : ST_DONE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_addr(x_q, y_q);
		mem_wd = {walls_q, walls_q};
		mem_ra = cell_addr(x_q, y_q);
		unique case (state_q)
			ST_CENTER: mem_we = 1'b1;
			ST_NB_RD:  mem_ra = cell_addr(nb_x, nb_y);
			ST_NB_WR: begin
				mem_we = 1'b1;
				mem_wa = cell_addr(nb_x, nb_y);
				mem_wd = nb_cell;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dir_q       <= DIR_NORTH;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_CENTER)
				dir_q <= DIR_NORTH;
			else if ((state_q == ST_NB_WR) || (state_q == ST_NB_RD && !nb_exists))
				dir_q <= dir_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			walls_q <= walls_in;
			res_q   <= 8'd0;
		end
		if (state_q == ST_CENTER)
			res_q <= {walls_q, walls_q};
		if (state_q == ST_CELL_WAIT)
			res_q <= rd_cell;
		if (out_load)
			cell_value_q <= res_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELL_CNT; i++)
				vld_q[i] <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[mem_wa] <= 1'b1;
			rd_vld_q <= vld_q[mem_ra];
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;

endmodule
